// File: design/rc6ke_pkg.sv
`timescale 1ns / 1ps
// rc6ke_pkg: shared types, register codes, magic constants and word helpers
// for the rc6 key schedule block. No dependencies.
package rc6ke_pkg;

	localparam int WORD_W = 64;
	localparam int IDX_W  = 6;
	localparam int BYTE_W = 8;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 6;

	// register indexes on the config port
	localparam logic [CFG_AW-1:0] REG_WORD_SIZE = 2'd0;
	localparam logic [CFG_AW-1:0] REG_ROUNDS    = 2'd1;
	localparam logic [CFG_AW-1:0] REG_KEY_BYTES = 2'd2;

	// word size modes, code three behaves as 64 bits
	localparam logic [1:0] MODE_16 = 2'd0;
	localparam logic [1:0] MODE_32 = 2'd1;
	localparam logic [1:0] MODE_64 = 2'd2;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic key_wr;
		logic clr_loaded;
		logic pk_rd;
		logic fill_wr;
		logic fill_first;
		logic mx_rd;
		logic mx_init;
		logic mx_p1;
		logic mx_p2;
		logic mx_p3;
		logic mx_byp;
		logic em_rd;
		logic em_ld;
		logic em_last;
	} cmd_t;

	function automatic logic [WORD_W-1:0] p_const(input logic [1:0] mode);
		logic [WORD_W-1:0] res;
		unique case (mode)
			MODE_16: res = 64'h0000_0000_0000_B7E1;
			MODE_32: res = 64'h0000_0000_B7E1_5163;
			default: res = 64'hB7E1_5162_8AED_2A6B;
		endcase
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] q_const(input logic [1:0] mode);
		logic [WORD_W-1:0] res;
		unique case (mode)
			MODE_16: res = 64'h0000_0000_0000_9E37;
			MODE_32: res = 64'h0000_0000_9E37_79B9;
			default: res = 64'h9E37_79B9_7F4A_7C15;
		endcase
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] word_mask(input logic [1:0] mode);
		logic [WORD_W-1:0] res;
		unique case (mode)
			MODE_16: res = 64'h0000_0000_0000_FFFF;
			MODE_32: res = 64'h0000_0000_FFFF_FFFF;
			default: res = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return res;
	endfunction

	// w - 1, used to reduce a rotate amount mod w
	function automatic logic [5:0] amt_mask(input logic [1:0] mode);
		logic [5:0] res;
		unique case (mode)
			MODE_16: res = 6'd15;
			MODE_32: res = 6'd31;
			default: res = 6'd63;
		endcase
		return res;
	endfunction

	// log2 of bytes per word
	function automatic logic [1:0] log2_bytes(input logic [1:0] mode);
		logic [1:0] res;
		unique case (mode)
			MODE_16: res = 2'd1;
			MODE_32: res = 2'd2;
			default: res = 2'd3;
		endcase
		return res;
	endfunction

	// bytes per word minus one
	function automatic logic [2:0] byte_mask(input logic [1:0] mode);
		logic [2:0] res;
		unique case (mode)
			MODE_16: res = 3'd1;
			MODE_32: res = 3'd3;
			default: res = 3'd7;
		endcase
		return res;
	endfunction

	// left rotate of the low w bits, result zero above w
	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
		input logic [5:0] s, input logic [1:0] mode);
		logic [31:0]       d16;
		logic [63:0]       d32;
		logic [127:0]      d64;
		logic [WORD_W-1:0] res;
		d16 = {x[15:0], x[15:0]} << s[3:0];
		d32 = {x[31:0], x[31:0]} << s[4:0];
		d64 = {x, x} << s;
		unique case (mode)
			MODE_16: res = {48'd0, d16[31:16]};
			MODE_32: res = {32'd0, d32[63:32]};
			default: res = d64[127:64];
		endcase
		return res;
	endfunction

endpackage

// File: design/rc6ke_ctrl.sv
`timescale 1ns / 1ps
// rc6ke_ctrl: sequencer for key load, key word packing, table fill, mixing
// and word output. Uses rc6ke_pkg; drives rc6ke_dp through cmd_t.
module rc6ke_ctrl #(
	parameter int MAX_ROUNDS    = 20,
	parameter int MAX_KEY_BYTES = 32,
	localparam int TD  = 2 * MAX_ROUNDS + 4,
	localparam int TIW = $clog2(TD),
	localparam int TCW = $clog2(TD + 1),
	localparam int KW  = (MAX_KEY_BYTES + 1) / 2,
	localparam int KIW = (KW > 1) ? $clog2(KW) : 1,
	localparam int KCW = $clog2(KW + 1),
	localparam int PKW = $clog2(MAX_KEY_BYTES + 8),
	localparam int STW = $clog2(3 * ((TD > KW) ? TD : KW) + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	input  logic                 s_last,
	output logic                 s_ready,
	input  logic                 out_free,
	input  logic [TCW-1:0]       t_cnt,
	input  logic [KCW-1:0]       c_cnt,
	input  logic [PKW-1:0]       npk,
	input  logic [STW-1:0]       steps,
	output rc6ke_pkg::cmd_t      cmd,
	output logic [TIW-1:0]       s_ra,
	output logic [TIW-1:0]       s_wa,
	output logic [KIW-1:0]       l_ra,
	output logic [KIW-1:0]       l_wa,
	output logic [PKW-1:0]       pk_k
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PACK,
		ST_FILL,
		ST_MRD,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_ERD,
		ST_ELD
	} state_t;

	state_t         state_q;
	logic [TIW-1:0] idx_q;
	logic [KIW-1:0] j_q;
	logic [PKW-1:0] k_q;
	logic [STW-1:0] step_q;

	logic           i_last;
	logic           k_last;
	logic           step_last;
	logic [TIW-1:0] i_nx;
	logic [KIW-1:0] j_nx;

	assign i_last    = (TCW'(idx_q) + TCW'(1)) == t_cnt;
	assign k_last    = (k_q + PKW'(1)) == npk;
	assign step_last = (step_q + STW'(1)) == steps;
	assign i_nx      = i_last ? '0 : idx_q + TIW'(1);
	assign j_nx      = ((KCW'(j_q) + KCW'(1)) == c_cnt) ? '0 : j_q + KIW'(1);

	assign s_ready = (state_q == ST_IDLE);
	assign s_wa    = idx_q;
	assign l_wa    = j_q;
	assign pk_k    = k_q;

	always_comb begin
		cmd  = '0;
		s_ra = idx_q;
		l_ra = j_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.key_wr = s_valid;
			end
			ST_PACK: begin
				cmd.pk_rd = 1'b1;
			end
			ST_FILL: begin
				cmd.fill_wr    = 1'b1;
				cmd.fill_first = (idx_q == '0);
				cmd.clr_loaded = 1'b1;
			end
			ST_MRD: begin
				cmd.mx_rd   = 1'b1;
				cmd.mx_init = 1'b1;
			end
			ST_M1: begin
				cmd.mx_p1 = 1'b1;
			end
			ST_M2: begin
				cmd.mx_p2 = 1'b1;
				// single key word: the word just written is still in b
				cmd.mx_byp = (c_cnt == KCW'(1)) && (step_q != '0);
			end
			ST_M3: begin
				cmd.mx_p3 = 1'b1;
				if (!step_last) begin
					cmd.mx_rd = 1'b1;
					s_ra      = i_nx;
					l_ra      = j_nx;
				end
			end
			ST_ERD: begin
				cmd.em_rd = 1'b1;
			end
			ST_ELD: begin
				if (out_free) begin
					cmd.em_ld   = 1'b1;
					cmd.em_last = i_last;
					if (!i_last) begin
						cmd.em_rd = 1'b1;
						s_ra      = idx_q + TIW'(1);
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			j_q     <= '0;
			k_q     <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_valid && s_last) begin
						state_q <= ST_PACK;
						k_q     <= '0;
					end
				end
				ST_PACK: begin
					k_q <= k_q + PKW'(1);
					if (k_last) begin
						state_q <= ST_FILL;
						idx_q   <= '0;
					end
				end
				ST_FILL: begin
					idx_q <= idx_q + TIW'(1);
					if (i_last) begin
						state_q <= ST_MRD;
						idx_q   <= '0;
						j_q     <= '0;
						step_q  <= '0;
					end
				end
				ST_MRD: begin
					state_q <= ST_M1;
				end
				ST_M1: begin
					state_q <= ST_M2;
				end
				ST_M2: begin
					state_q <= ST_M3;
				end
				ST_M3: begin
					idx_q  <= i_nx;
					j_q    <= j_nx;
					step_q <= step_q + STW'(1);
					if (step_last) begin
						state_q <= ST_ERD;
						idx_q   <= '0;
					end else begin
						state_q <= ST_M1;
					end
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					if (out_free) begin
						if (i_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + TIW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/rc6ke_dp.sv
`timescale 1ns / 1ps
// rc6ke_dp: key byte store, key word table, round key table, mixing unit and
// output register. Uses rc6ke_pkg; commanded by rc6ke_ctrl.
module rc6ke_dp #(
	parameter int MAX_ROUNDS    = 20,
	parameter int MAX_KEY_BYTES = 32,
	localparam int TD  = 2 * MAX_ROUNDS + 4,
	localparam int TIW = $clog2(TD),
	localparam int KW  = (MAX_KEY_BYTES + 1) / 2,
	localparam int KIW = (KW > 1) ? $clog2(KW) : 1,
	localparam int KBW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
	localparam int LDW = $clog2(MAX_KEY_BYTES + 1),
	localparam int PKW = $clog2(MAX_KEY_BYTES + 8)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rc6ke_pkg::cmd_t               cmd,
	input  logic [1:0]                    mode,
	input  logic [LDW-1:0]                b_eff,
	input  logic [rc6ke_pkg::BYTE_W-1:0]  key_byte,
	input  logic [TIW-1:0]                s_ra,
	input  logic [TIW-1:0]                s_wa,
	input  logic [KIW-1:0]                l_ra,
	input  logic [KIW-1:0]                l_wa,
	input  logic [PKW-1:0]                pk_k,
	output logic                          out_free,
	input  logic                          m_ready,
	output logic                          m_valid,
	output logic [rc6ke_pkg::WORD_W-1:0]  round_key,
	output logic [rc6ke_pkg::IDX_W-1:0]   word_index,
	output logic                          last_word
);

	localparam int W = rc6ke_pkg::WORD_W;

	logic [rc6ke_pkg::BYTE_W-1:0] key_mem_q [MAX_KEY_BYTES];
	logic [W-1:0]                 l_mem_q [KW];
	logic [W-1:0]                 s_mem_q [TD];

	logic [LDW-1:0] bytes_loaded_q;

	// pack stage
	logic                         pk_v_s1;
	logic                         pk_ok_s1;
	logic [PKW-1:0]               pk_k_s1;
	logic [rc6ke_pkg::BYTE_W-1:0] kb_s1;
	logic [W-1:0]                 acc_q;
	logic [2:0]                   pk_pos;
	logic [W-1:0]                 pk_byte;
	logic [W-1:0]                 acc_new;
	logic                         pk_wr;
	logic [KIW-1:0]               pk_wa;

	// mixing
	logic [W-1:0] s_rd_q;
	logic [W-1:0] l_rd_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] sum1_q;
	logic [W-1:0] sum2_q;
	logic [5:0]   amt_q;
	logic [W-1:0] fill_q;
	logic [W-1:0] fill_val;
	logic [W-1:0] a_new;
	logic [W-1:0] b_new;
	logic [W-1:0] l_sel;
	logic [W-1:0] ab_sum;

	// output register
	logic                        m_valid_q;
	logic [W-1:0]                key_q;
	logic [rc6ke_pkg::IDX_W-1:0] idx_q;
	logic                        last_q;

	assign pk_pos  = 3'(pk_k_s1) & rc6ke_pkg::byte_mask(mode);
	assign pk_byte = pk_ok_s1 ? W'(kb_s1) : '0;
	assign acc_new = ((pk_pos == 3'd0) ? '0 : acc_q) | (pk_byte << {pk_pos, 3'b000});
	assign pk_wr   = pk_v_s1 && (pk_pos == rc6ke_pkg::byte_mask(mode));
	assign pk_wa   = KIW'(pk_k_s1 >> rc6ke_pkg::log2_bytes(mode));

	assign fill_val = cmd.fill_first ? rc6ke_pkg::p_const(mode)
		: (fill_q + rc6ke_pkg::q_const(mode)) & rc6ke_pkg::word_mask(mode);

	assign a_new  = rc6ke_pkg::rotl(sum1_q, 6'd3, mode);
	assign l_sel  = cmd.mx_byp ? b_q : l_rd_q;
	assign ab_sum = a_new + b_q;
	assign b_new  = rc6ke_pkg::rotl(sum2_q, amt_q, mode);

	assign out_free   = !m_valid_q || m_ready;
	assign m_valid    = m_valid_q;
	assign round_key  = key_q;
	assign word_index = idx_q;
	assign last_word  = last_q;

	// key byte store, entries at or above the fill count read as zero
	always_ff @(posedge clk) begin
		if (cmd.key_wr && (bytes_loaded_q < MAX_KEY_BYTES)) begin
			key_mem_q[bytes_loaded_q[KBW-1:0]] <= key_byte;
		end
		if (cmd.pk_rd && (pk_k < MAX_KEY_BYTES)) begin
			kb_s1 <= key_mem_q[pk_k[KBW-1:0]];
		end
	end

	// key word table
	always_ff @(posedge clk) begin
		if (pk_wr) begin
			l_mem_q[pk_wa] <= acc_new;
		end else if (cmd.mx_p3) begin
			l_mem_q[l_wa] <= b_new;
		end
		if (cmd.mx_rd) begin
			l_rd_q <= l_mem_q[l_ra];
		end
	end

	// round key table
	always_ff @(posedge clk) begin
		if (cmd.fill_wr) begin
			s_mem_q[s_wa] <= fill_val;
		end else if (cmd.mx_p2) begin
			s_mem_q[s_wa] <= a_new;
		end
		if (cmd.mx_rd || cmd.em_rd) begin
			s_rd_q <= s_mem_q[s_ra];
		end
	end

	always_ff @(posedge clk) begin
		pk_k_s1  <= pk_k;
		pk_ok_s1 <= (pk_k < b_eff) && (pk_k < bytes_loaded_q);
		if (pk_v_s1) begin
			acc_q <= acc_new;
		end
		if (cmd.fill_wr) begin
			fill_q <= fill_val;
		end
		if (cmd.mx_p1) begin
			sum1_q <= s_rd_q + a_q + b_q;
		end
		if (cmd.mx_p2) begin
			sum2_q <= l_sel + a_new + b_q;
			amt_q  <= ab_sum[5:0] & rc6ke_pkg::amt_mask(mode);
		end
		if (cmd.em_ld) begin
			key_q  <= s_rd_q;
			idx_q  <= rc6ke_pkg::IDX_W'(s_wa);
			last_q <= cmd.em_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_loaded_q <= '0;
			pk_v_s1        <= 1'b0;
			a_q            <= '0;
			b_q            <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			if (cmd.clr_loaded) begin
				bytes_loaded_q <= '0;
			end else if (cmd.key_wr && (bytes_loaded_q < MAX_KEY_BYTES)) begin
				bytes_loaded_q <= bytes_loaded_q + LDW'(1);
			end
			pk_v_s1 <= cmd.pk_rd;
			if (cmd.mx_init) begin
				a_q <= '0;
				b_q <= '0;
			end else begin
				if (cmd.mx_p2) begin
					a_q <= a_new;
				end
				if (cmd.mx_p3) begin
					b_q <= b_new;
				end
			end
			if (cmd.em_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/rc6_key_expansion.sv
`timescale 1ns / 1ps
// rc6_key_expansion: top level with config registers, schedule sizing,
// sequencer rc6ke_ctrl and datapath rc6ke_dp. Uses rc6ke_pkg.
//
// Key bytes are taken one per cycle while the block is idle; the byte with
// tlast starts a schedule and the input stays not ready until the last round
// key word has been handed to the output register. A schedule packs the key
// bytes into c key words of u bytes, fills a table of t = 2r+4 words, runs
// the mixing steps, each a sum, a fixed rotate with the second sum and a
// variable rotate, then sends one word per cycle out while the downstream
// side is ready. Config is sampled throughout a schedule and must only
// change while idle.
module rc6_key_expansion #(
	parameter int MAX_ROUNDS    = 20,
	parameter int MAX_KEY_BYTES = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rc6ke_pkg::CFG_AW-1:0] cfg_index,
	input  logic [rc6ke_pkg::CFG_DW-1:0] cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // key_byte[7:0]
	input  logic                         s_axis_tlast,  // last_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [71:0]                  m_axis_tdata,  // round_key[63:0], word_index[69:64], zero
	output logic                         m_axis_tlast   // last_word
);

	localparam int TD  = 2 * MAX_ROUNDS + 4;
	localparam int TCW = $clog2(TD + 1);
	localparam int KW  = (MAX_KEY_BYTES + 1) / 2;
	localparam int KCW = $clog2(KW + 1);
	localparam int LDW = $clog2(MAX_KEY_BYTES + 1);
	localparam int CSW = LDW + 1;
	localparam int PKW = $clog2(MAX_KEY_BYTES + 8);
	localparam int STW = $clog2(3 * ((TD > KW) ? TD : KW) + 1);
	localparam int MW  = (TCW > KCW) ? TCW : KCW;
	localparam int TIW = $clog2(TD);
	localparam int KIW = (KW > 1) ? $clog2(KW) : 1;

	logic [1:0] mode_q;
	logic [4:0] rounds_q;
	logic [5:0] key_bytes_q;

	logic [4:0]     r_eff;
	logic [TCW-1:0] t_cnt;
	logic [LDW-1:0] b_eff;
	logic [CSW-1:0] c_sum;
	logic [CSW-1:0] c_raw;
	logic [KCW-1:0] c_cnt;
	logic [PKW-1:0] npk;
	logic [MW-1:0]  mx;
	logic [STW-1:0] steps;

	rc6ke_pkg::cmd_t          cmd;
	logic [TIW-1:0]           s_ra;
	logic [TIW-1:0]           s_wa;
	logic [KIW-1:0]           l_ra;
	logic [KIW-1:0]           l_wa;
	logic [PKW-1:0]           pk_k;
	logic                     out_free;
	logic [rc6ke_pkg::WORD_W-1:0] round_key;
	logic [rc6ke_pkg::IDX_W-1:0]  word_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= rc6ke_pkg::MODE_32;
			rounds_q    <= 5'd20;
			key_bytes_q <= 6'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rc6ke_pkg::REG_WORD_SIZE: mode_q      <= cfg_data[1:0];
				rc6ke_pkg::REG_ROUNDS:    rounds_q    <= cfg_data[4:0];
				rc6ke_pkg::REG_KEY_BYTES: key_bytes_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// schedule sizing from the config registers
	always_comb begin
		if (rounds_q == 5'd0) begin
			r_eff = 5'd1;
		end else if (rounds_q > MAX_ROUNDS) begin
			r_eff = 5'(MAX_ROUNDS);
		end else begin
			r_eff = rounds_q;
		end
		t_cnt = TCW'({r_eff, 1'b0}) + TCW'(4);

		if (key_bytes_q > MAX_KEY_BYTES) begin
			b_eff = LDW'(MAX_KEY_BYTES);
		end else begin
			b_eff = LDW'(key_bytes_q);
		end
		c_sum = CSW'(b_eff) + CSW'(rc6ke_pkg::byte_mask(mode_q));
		c_raw = c_sum >> rc6ke_pkg::log2_bytes(mode_q);
		// empty key still uses one zero word
		c_cnt = (c_raw == '0) ? KCW'(1) : KCW'(c_raw);
		npk   = PKW'(c_cnt) << rc6ke_pkg::log2_bytes(mode_q);

		mx    = (MW'(t_cnt) > MW'(c_cnt)) ? MW'(t_cnt) : MW'(c_cnt);
		steps = (STW'(mx) << 1) + STW'(mx);
	end

	rc6ke_ctrl #(
		.MAX_ROUNDS    (MAX_ROUNDS),
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_last   (s_axis_tlast),
		.s_ready  (s_axis_tready),
		.out_free (out_free),
		.t_cnt    (t_cnt),
		.c_cnt    (c_cnt),
		.npk      (npk),
		.steps    (steps),
		.cmd      (cmd),
		.s_ra     (s_ra),
		.s_wa     (s_wa),
		.l_ra     (l_ra),
		.l_wa     (l_wa),
		.pk_k     (pk_k)
	);

	rc6ke_dp #(
		.MAX_ROUNDS    (MAX_ROUNDS),
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode_q),
		.b_eff      (b_eff),
		.key_byte   (s_axis_tdata),
		.s_ra       (s_ra),
		.s_wa       (s_wa),
		.l_ra       (l_ra),
		.l_wa       (l_wa),
		.pk_k       (pk_k),
		.out_free   (out_free),
		.m_ready    (m_axis_tready),
		.m_valid    (m_axis_tvalid),
		.round_key  (round_key),
		.word_index (word_index),
		.last_word  (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, word_index, round_key};

endmodule

// File: design/rc6ke_chk.sv
`timescale 1ns / 1ps
// rc6ke_chk: port level checks for rc6_key_expansion, bound to the top level.
// No package dependencies.
module rc6ke_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// an accepted final key byte closes the input
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input ready right after final key byte");

	a_no_input_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready while a run is still being sent");

	// words of a run follow without a gap once taken
	a_run_continuous: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a run of round key words");

	a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
		!m_axis_tvalid || (m_axis_tdata[69:64] == 6'd0))
		else $error("run does not start at word zero");

endmodule

bind rc6_key_expansion rc6ke_chk u_rc6ke_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
